/* rtl/core/qrr_pkg.sv */
// ----------------------------------------------------------------------------
// qrr_pkg
// Shared types and constants for the key queue with rotate-and-remove.
// ----------------------------------------------------------------------------
package qrr_pkg;

  // fixed field widths of the request and result ports
  localparam int KEY_W   = 56;
  localparam int VALUE_W = 56;

  // request command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_FULL      = 2'd0,
    KIND_NOT_FOUND = 2'd1,
    KIND_POSITION  = 2'd2,
    KIND_ENTRY     = 2'd3
  } kind_t;

  // source of the result value
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_POS,
    SEL_KEY
  } out_sel_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_POS,
    ST_LIST,
    ST_EMIT_NF,
    ST_EMIT_FULL
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic     key_load;
    logic     ins_write;
    logic     rd_first;
    logic     rd_next;
    logic     scan_rotate;
    logic     scan_remove;
    logic     out_load;
    kind_t    out_kind;
    out_sel_t out_sel;
    logic     out_last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic count_zero;
    logic match;
    logic scan_done;
    logic list_last;
    logic out_free;
  } status_t;

endpackage

/* rtl/core/qrr_ctrl.sv */
// ----------------------------------------------------------------------------
// qrr_ctrl
// Sequencer for insert, scan-and-rotate, and result listing.
// ----------------------------------------------------------------------------
module qrr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             command,
  input  qrr_pkg::status_t st,
  output qrr_pkg::cmd_t    cmd
);
  import qrr_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.key_load = 1'b1;
          if (command == CMD_INSERT) begin
            if (st.full) begin
              state_next = ST_EMIT_FULL;
            end else begin
              cmd.ins_write = 1'b1;
            end
          end else if (st.count_zero) begin
            state_next = ST_EMIT_NF;
          end else begin
            cmd.rd_first = 1'b1;
            state_next   = ST_SCAN;
          end
        end
      end
      // one entry compared per cycle, mismatches go to the tail
      ST_SCAN: begin
        if (st.match) begin
          cmd.scan_remove = 1'b1;
          state_next      = ST_EMIT_POS;
        end else begin
          cmd.scan_rotate = 1'b1;
          if (st.scan_done) begin
            state_next = ST_EMIT_NF;
          end
        end
      end
      ST_EMIT_POS: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_POSITION;
          cmd.out_sel  = SEL_POS;
          cmd.out_last = st.count_zero;
          if (st.count_zero) begin
            state_next = ST_IDLE;
          end else begin
            cmd.rd_first = 1'b1;
            state_next   = ST_LIST;
          end
        end
      end
      // one remaining entry per cycle while the output drains
      ST_LIST: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_ENTRY;
          cmd.out_sel  = SEL_KEY;
          cmd.out_last = st.list_last;
          if (st.list_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      ST_EMIT_NF: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_NOT_FOUND;
          cmd.out_sel  = SEL_ZERO;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_EMIT_FULL: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_FULL;
          cmd.out_sel  = SEL_ZERO;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/qrr_dp.sv */
// ----------------------------------------------------------------------------
// qrr_dp
// Key memory, queue pointers, scan counters and the result register.
// ----------------------------------------------------------------------------
module qrr_dp #(
  parameter int QUEUE_DEPTH = 32,
  parameter int KEY_BITS    = 56
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [qrr_pkg::KEY_W-1:0]    plate_key,
  input  qrr_pkg::cmd_t                cmd,
  output qrr_pkg::status_t             st,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [qrr_pkg::VALUE_W-1:0]  result_value,
  output logic                         last
);
  import qrr_pkg::*;

  localparam int SW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [SW-1:0] mem [QUEUE_DEPTH];
  logic [SW-1:0] rd_data;
  logic [SW-1:0] key;
  logic [PW-1:0] front;
  logic [PW-1:0] tail;
  logic [PW-1:0] lp;
  logic [CW-1:0] count;
  logic [CW-1:0] scanned;
  logic [CW-1:0] idx;
  logic [PW-1:0] front_inc;
  logic [PW-1:0] tail_inc;
  logic [PW-1:0] lp_inc;
  logic [VALUE_W-1:0] value_mux;

  // wrap-around increment of a slot pointer
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign front_inc = ptr_inc(front);
  assign tail_inc  = ptr_inc(tail);
  assign lp_inc    = ptr_inc(lp);

  // key memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      mem[tail] <= plate_key[SW-1:0];
    end else if (cmd.scan_rotate) begin
      mem[tail] <= rd_data;
    end
    if (cmd.rd_first) begin
      rd_data <= mem[front];
    end else if (cmd.scan_rotate) begin
      rd_data <= mem[front_inc];
    end else if (cmd.rd_next) begin
      rd_data <= mem[lp];
    end
  end

  // search key
  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      key <= plate_key[SW-1:0];
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.scan_rotate || cmd.scan_remove) begin
        front <= front_inc;
      end
      if (cmd.ins_write || cmd.scan_rotate) begin
        tail <= tail_inc;
      end
      if (cmd.ins_write) begin
        count <= count + CW'(1);
      end else if (cmd.scan_remove) begin
        count <= count - CW'(1);
      end
    end
  end

  // scan position and listing counters
  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      scanned <= '0;
      idx     <= '0;
      lp      <= front_inc;
    end else begin
      if (cmd.scan_rotate || cmd.scan_remove) begin
        scanned <= scanned + CW'(1);
      end
      if (cmd.rd_next) begin
        idx <= idx + CW'(1);
        lp  <= lp_inc;
      end
    end
  end

  // result value select
  always_comb begin
    case (cmd.out_sel)
      SEL_POS: value_mux = VALUE_W'(scanned);
      SEL_KEY: value_mux = VALUE_W'(rd_data);
      default: value_mux = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind         <= cmd.out_kind;
      result_value <= value_mux;
      last         <= cmd.out_last;
    end
  end

  // status back to the controller
  always_comb begin
    st.full       = (count == CW'(QUEUE_DEPTH));
    st.count_zero = (count == '0);
    st.match      = (rd_data == key);
    st.scan_done  = ((scanned + CW'(1)) == count);
    st.list_last  = ((idx + CW'(1)) == count);
    st.out_free   = !out_valid || out_ready;
  end

endmodule

/* rtl/core/queue_rotate_remove_by_key.sv */
// ----------------------------------------------------------------------------
// queue_rotate_remove_by_key
// FIFO of keys; remove scans from the front, rotating mismatches to the tail,
// then reports the position and lists the remaining keys, or reports not found.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid/in_ready    command, plate_key
//   out      out_valid/out_ready  kind, result_value, last
//
// A remove scans entries from the front in the compare loop, then emits the
// position and the remaining keys while the output drains, all through the
// single memory read port.
// Requests are taken only while the sequencer is idle; a waiting result
// never blocks the next request. Output stalls pause the listing.
// Reset empties the queue; the key memory itself is not cleared.
// ----------------------------------------------------------------------------
module queue_rotate_remove_by_key #(
  parameter int QUEUE_DEPTH = 32,
  parameter int KEY_BITS    = 56
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic [qrr_pkg::KEY_W-1:0]    plate_key,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [qrr_pkg::VALUE_W-1:0]  result_value,
  output logic                         last
);
  import qrr_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer
  qrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .st       (st),
    .cmd      (cmd)
  );

  // storage and result path
  qrr_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .plate_key    (plate_key),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .result_value (result_value),
    .last         (last)
  );

  // a queue cannot be both full and empty
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(st.full && st.count_zero))
    else $error("queue reports full and empty");

  // an insert write only on an accepted insert request with room
  a_ins_write: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> (in_valid && in_ready && (command == CMD_INSERT) && !st.full))
    else $error("insert write without accepted request");

  // never overwrite a result that is still waiting
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result register overwritten");

  // a matching entry is never rotated
  a_rotate: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rotate |-> !st.match)
    else $error("matching entry rotated");

endmodule

/* test/tb_queue_rotate_remove_by_key.sv */
// ----------------------------------------------------------------------------
// tb_queue_rotate_remove_by_key
// Self-checking bench for the rotate-and-remove key queue. A short table of
// directed requests runs first, then random insert/remove traffic in phases
// that fill the queue to saturation and drain it again. Results of typed rows
// are tabled, the rest predicted by a behavioral queue copy, checked in order.
// ----------------------------------------------------------------------------
module tb_queue_rotate_remove_by_key;
  timeunit 1ns;
  timeprecision 1ps;

  import qrr_pkg::*;

  localparam int DEPTH        = 32;
  localparam int RANDOM_ITEMS = 280;
  localparam int CALM_FROM    = 240;
  localparam int POOL_SIZE    = 8;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int N_DIRECTED   = 22;

  localparam logic [KEY_W-1:0] KEY_ZERO  = '0;
  localparam logic [KEY_W-1:0] KEY_ONES  = '1;
  localparam logic [KEY_W-1:0] KEY_PLATE = 56'h41424344454647;
  localparam logic [KEY_W-1:0] KEY_MISS  = 56'h5a5a3031323334;
  localparam logic [KEY_W-1:0] KEY_ALT_A = 56'haaaaaaaaaaaaaa;
  localparam logic [KEY_W-1:0] KEY_ALT_5 = 56'h55555555555555;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } queue_result_t;

  typedef struct {
    logic               cmd;
    logic [KEY_W-1:0]   key;
    bit                 typed;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } stim_row_t;

  // directed requests; typed rows carry their single expected result
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_REMOVE, KEY_ZERO,  1'b1, KIND_NOT_FOUND, 56'd0, 1'b1},
    '{CMD_REMOVE, KEY_ONES,  1'b1, KIND_NOT_FOUND, 56'd0, 1'b1},
    '{CMD_INSERT, KEY_ZERO,  1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_REMOVE, KEY_ZERO,  1'b1, KIND_POSITION,  56'd1, 1'b1},
    '{CMD_INSERT, KEY_ONES,  1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_INSERT, KEY_ZERO,  1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_INSERT, KEY_PLATE, 1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_REMOVE, KEY_MISS,  1'b1, KIND_NOT_FOUND, 56'd0, 1'b1},
    '{CMD_REMOVE, KEY_PLATE, 1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_REMOVE, KEY_ONES,  1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_REMOVE, KEY_ZERO,  1'b1, KIND_POSITION,  56'd1, 1'b1},
    '{CMD_INSERT, KEY_ALT_A, 1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_INSERT, KEY_ALT_5, 1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_INSERT, KEY_ZERO,  1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_INSERT, KEY_ALT_A, 1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_REMOVE, KEY_ALT_A, 1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_REMOVE, KEY_ALT_A, 1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_REMOVE, KEY_ALT_A, 1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_INSERT, KEY_ONES,  1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_REMOVE, KEY_ZERO,  1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_REMOVE, KEY_ALT_5, 1'b0, KIND_FULL,      56'd0, 1'b0},
    '{CMD_REMOVE, KEY_ONES,  1'b0, KIND_FULL,      56'd0, 1'b0}
  };

  logic               clk;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic               command      = CMD_INSERT;
  logic [KEY_W-1:0]   plate_key    = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [1:0]         kind;
  logic [VALUE_W-1:0] result_value;
  logic               last;

  // behavioral copy of the key ring
  logic [KEY_W-1:0]   key_ring [DEPTH];
  logic [4:0]         ring_head;
  logic [5:0]         ring_count;

  queue_result_t      expected_results [$];
  logic [KEY_W-1:0]   key_pool [POOL_SIZE];
  bit                 calm         = 1'b0;
  int                 errors       = 0;
  int                 results_seen = 0;
  int                 full_seen    = 0;
  int                 match_seen   = 0;
  int                 requests     = 0;
  int                 cycle_count  = 0;

  queue_rotate_remove_by_key #(
    .QUEUE_DEPTH(DEPTH),
    .KEY_BITS   (KEY_W)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .plate_key   (plate_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .result_value(result_value),
    .last        (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] random_key();
    return KEY_W'({$urandom(), $urandom()});
  endfunction

  // apply one request to the key ring and list the results it causes
  task automatic predict_queue_op(input logic cmd, input logic [KEY_W-1:0] key,
                                  output queue_result_t outs [$]);
    int scanned;
    bit found;
    outs = {};
    if (cmd == CMD_INSERT) begin
      if (ring_count >= DEPTH) begin
        outs.push_back('{KIND_FULL, '0, 1'b1});
      end else begin
        key_ring[5'(ring_head + ring_count)] = key;
        ring_count = ring_count + 6'd1;
      end
      return;
    end
    // scan from the front, mismatches rotate to the tail
    scanned = 0;
    found = 1'b0;
    while (!found && scanned < ring_count) begin
      scanned++;
      if (key_ring[ring_head] == key) begin
        found = 1'b1;
      end else begin
        key_ring[5'(ring_head + ring_count)] = key_ring[ring_head];
        ring_head = ring_head + 1'b1;
      end
    end
    if (!found) begin
      outs.push_back('{KIND_NOT_FOUND, '0, 1'b1});
      return;
    end
    // drop the match, then list what remains
    ring_head = ring_head + 1'b1;
    ring_count = ring_count - 1'b1;
    outs.push_back('{KIND_POSITION, VALUE_W'(scanned), ring_count == 0});
    for (int i = 0; i < ring_count; i++) begin
      outs.push_back('{KIND_ENTRY, key_ring[5'(ring_head + i)], i + 1 == ring_count});
    end
  endtask

  // present one request and hold it until accepted
  task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    plate_key <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests++;
  endtask

  // result-side stalls
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    queue_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d value %h last %0b", kind, result_value, last);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (kind !== exp_res.kind) begin
          $error("kind: expected %0d, actual %0d", exp_res.kind, kind);
          errors++;
        end
        if (result_value !== exp_res.value) begin
          $error("result_value: expected %h, actual %h", exp_res.value, result_value);
          errors++;
        end
        if (last !== exp_res.last) begin
          $error("last: expected %0b, actual %0b", exp_res.last, last);
          errors++;
        end
        if (exp_res.kind == KIND_FULL) full_seen++;
        if (exp_res.kind == KIND_POSITION) match_seen++;
      end
    end
  end

  // main stimulus
  initial begin
    queue_result_t    outs [$];
    logic             cmd;
    logic [KEY_W-1:0] key;
    int               ins_pct;
    int               pick;

    ring_head  = '0;
    ring_count = '0;
    foreach (key_ring[i]) key_ring[i] = '0;
    foreach (key_pool[i]) key_pool[i] = random_key();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].cmd, directed_rows[r].key);
      predict_queue_op(directed_rows[r].cmd, directed_rows[r].key, outs);
      if (directed_rows[r].typed) begin
        expected_results.push_back('{directed_rows[r].kind, directed_rows[r].value,
                                     directed_rows[r].last});
      end else begin
        foreach (outs[j]) expected_results.push_back(outs[j]);
      end
    end

    // random traffic: balanced, fill to saturation, drain, then calm
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < 100) ins_pct = 55;
      else if (n < 180) ins_pct = 85;
      else if (n < CALM_FROM) ins_pct = 25;
      else ins_pct = 50;
      calm = (n >= CALM_FROM);
      cmd  = ($urandom_range(1, 100) <= ins_pct) ? CMD_INSERT : CMD_REMOVE;
      pick = $urandom_range(0, 99);
      if (cmd == CMD_INSERT) begin
        key = (pick < 50) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : random_key();
      end else if (pick < 65 && ring_count != 0) begin
        key = key_ring[5'(ring_head + $urandom_range(0, ring_count - 1))];
      end else if (pick < 85) begin
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        key = random_key();
      end
      send_request(cmd, key);
      predict_queue_op(cmd, key, outs);
      foreach (outs[j]) expected_results.push_back(outs[j]);
    end
    in_valid <= 1'b0;

    // drain and let the block settle
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests (%0d directed) and %0d checked results",
             requests, N_DIRECTED, results_seen);
    $display("including %0d inserts refused on a full queue and %0d matched removes",
             full_seen, match_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
